/* src/pgr_pkg.sv */
`default_nettype none

package pgr_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 14;

  localparam int DIM_W  = COORD_BITS + 1;
  localparam int TX_W   = COORD_BITS + 2;
  localparam int COEF_W = 20;
  localparam int OFS_W  = 13;
  localparam int MODE_W = 3;
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 20;
  localparam int COL_W  = 8;

  localparam int P_W   = TX_W + COEF_W;
  localparam int X1_W  = P_W - FRAC_BITS + 1;
  localparam int R_W   = X1_W + COEF_W;
  localparam int Y1_W  = R_W - FRAC_BITS + 1;
  localparam int S_W   = Y1_W + COEF_W;
  localparam int ACC_W = S_W + 2;
  localparam int D_W   = ACC_W - FRAC_BITS;

  localparam int PIPE_DEPTH = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_CW90    = 3'd0,
    MODE_CCW90   = 3'd1,
    MODE_ROT180  = 3'd2,
    MODE_FLIP_H  = 3'd3,
    MODE_FLIP_V  = 3'd4,
    MODE_ROTATE  = 3'd5,
    MODE_SHEAR   = 3'd6
  } mode_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_MODE       = 3'd0,
    CFG_WIDTH      = 3'd1,
    CFG_HEIGHT     = 3'd2,
    CFG_COS        = 3'd3,
    CFG_SIN        = 3'd4,
    CFG_NEG_TAN    = 3'd5,
    CFG_OFFSET_X   = 3'd6,
    CFG_OFFSET_Y   = 3'd7
  } cfg_idx_t;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [D_W-1:0]   d_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] src_x;
    logic [COORD_BITS-1:0] src_y;
    logic [COL_W-1:0]      red;
    logic [COL_W-1:0]      green;
    logic [COL_W-1:0]      blue;
  } pix_req_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] dst_x;
    logic [COORD_BITS-1:0] dst_y;
    logic [COL_W-1:0]      out_red;
    logic [COL_W-1:0]      out_green;
    logic [COL_W-1:0]      out_blue;
    logic                  in_frame;
  } pix_res_t;

  typedef struct packed {
    mode_t                    mode;
    logic [DIM_W-1:0]         image_width;
    logic [DIM_W-1:0]         image_height;
    logic signed [COEF_W-1:0] cos_coef;
    logic signed [COEF_W-1:0] sin_coef;
    logic signed [COEF_W-1:0] neg_tan_half_coef;
    logic signed [OFS_W-1:0]  offset_x;
    logic signed [OFS_W-1:0]  offset_y;
  } cfg_t;

  function automatic d_t trunc_frac(acc_t v);
    acc_t bias;
    acc_t sum;
    acc_t sh;
    bias = v[ACC_W-1] ? acc_t'((1 << FRAC_BITS) - 1) : '0;
    sum  = v + bias;
    sh   = sum >>> FRAC_BITS;
    return sh[D_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* src/pgr_pipe.sv */
`default_nettype none

module pgr_pipe (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_vld,
  input  wire pgr_pkg::pix_req_t in_pix,
  input  wire pgr_pkg::cfg_t    cfg,
  output logic                  out_vld,
  output pgr_pkg::pix_res_t     out_res
);

  typedef struct packed {
    logic                                   ok;
    pgr_pkg::mode_t                         mode;
    logic signed [pgr_pkg::TX_W-1:0]        tx;
    logic signed [pgr_pkg::TX_W-1:0]        ty;
    logic signed [pgr_pkg::TX_W-1:0]        fdx;
    logic signed [pgr_pkg::TX_W-1:0]        fdy;
    logic [pgr_pkg::DIM_W-1:0]              fw;
    logic [pgr_pkg::DIM_W-1:0]              fh;
    logic [pgr_pkg::COL_W-1:0]              red;
    logic [pgr_pkg::COL_W-1:0]              green;
    logic [pgr_pkg::COL_W-1:0]              blue;
    logic signed [pgr_pkg::P_W-1:0]         pa;
    logic signed [pgr_pkg::P_W-1:0]         pb;
    logic signed [pgr_pkg::P_W-1:0]         pc;
    logic signed [pgr_pkg::P_W-1:0]         pd;
    logic signed [pgr_pkg::P_W-1:0]         q;
    logic signed [pgr_pkg::X1_W-1:0]        x1;
    logic signed [pgr_pkg::R_W-1:0]         r;
    logic signed [pgr_pkg::Y1_W-1:0]        y1;
    logic signed [pgr_pkg::S_W-1:0]         s;
    logic signed [pgr_pkg::D_W-1:0]         dx5;
    logic signed [pgr_pkg::D_W-1:0]         dy5;
    logic signed [pgr_pkg::D_W-1:0]         dx;
    logic signed [pgr_pkg::D_W-1:0]         dy;
  } pl_t;

  localparam int NST = pgr_pkg::PIPE_DEPTH - 1;

  pl_t                               st_r   [0:NST-1];
  pl_t                               st_nxt [0:NST-1];
  logic [pgr_pkg::PIPE_DEPTH-1:0]    vld_r;
  logic [pgr_pkg::PIPE_DEPTH-1:0]    vld_nxt;
  pgr_pkg::pix_res_t                 res_r;
  pgr_pkg::pix_res_t                 res_nxt;

  logic signed [pgr_pkg::TX_W-1:0]   xs;
  logic signed [pgr_pkg::TX_W-1:0]   ys;
  logic signed [pgr_pkg::TX_W-1:0]   ws;
  logic signed [pgr_pkg::TX_W-1:0]   hs;
  logic signed [pgr_pkg::TX_W-1:0]   one_s;
  pgr_pkg::d_t                       t_x1;
  pgr_pkg::d_t                       t_y1;
  pgr_pkg::d_t                       t_x2;
  logic                              ok_o;
  logic signed [pgr_pkg::D_W-1:0]    fw_s;
  logic signed [pgr_pkg::D_W-1:0]    fh_s;
  pl_t                               lst;

  always_comb begin
    xs    = $signed({2'b00, in_pix.src_x});
    ys    = $signed({2'b00, in_pix.src_y});
    ws    = $signed({1'b0, cfg.image_width});
    hs    = $signed({1'b0, cfg.image_height});
    one_s = $signed(pgr_pkg::TX_W'(1));

    st_nxt[0]       = '0;
    st_nxt[0].mode  = cfg.mode;
    st_nxt[0].red   = in_pix.red;
    st_nxt[0].green = in_pix.green;
    st_nxt[0].blue  = in_pix.blue;
    st_nxt[0].tx    = xs + pgr_pkg::TX_W'(cfg.offset_x);
    st_nxt[0].ty    = ys + pgr_pkg::TX_W'(cfg.offset_y);
    st_nxt[0].fw    = cfg.image_width;
    st_nxt[0].fh    = cfg.image_height;
    st_nxt[0].ok    = ({1'b0, in_pix.src_x} < cfg.image_width) &&
                      ({1'b0, in_pix.src_y} < cfg.image_height);
    case (cfg.mode)
      pgr_pkg::MODE_CW90: begin
        st_nxt[0].fw  = cfg.image_height;
        st_nxt[0].fh  = cfg.image_width;
        st_nxt[0].fdx = hs - one_s - ys;
        st_nxt[0].fdy = xs;
      end
      pgr_pkg::MODE_CCW90: begin
        st_nxt[0].fw  = cfg.image_height;
        st_nxt[0].fh  = cfg.image_width;
        st_nxt[0].fdx = ys;
        st_nxt[0].fdy = ws - one_s - xs;
      end
      pgr_pkg::MODE_ROT180: begin
        st_nxt[0].fdx = ws - one_s - xs;
        st_nxt[0].fdy = hs - one_s - ys;
      end
      pgr_pkg::MODE_FLIP_H: begin
        st_nxt[0].fdx = ws - one_s - xs;
        st_nxt[0].fdy = ys;
      end
      pgr_pkg::MODE_FLIP_V: begin
        st_nxt[0].fdx = xs;
        st_nxt[0].fdy = hs - one_s - ys;
      end
      pgr_pkg::MODE_ROTATE, pgr_pkg::MODE_SHEAR: begin
      end
      default: begin
        st_nxt[0].ok = 1'b0;
      end
    endcase

    st_nxt[1]    = st_r[0];
    st_nxt[1].pa = st_r[0].tx * cfg.cos_coef;
    st_nxt[1].pb = st_r[0].ty * cfg.sin_coef;
    st_nxt[1].pc = st_r[0].tx * cfg.sin_coef;
    st_nxt[1].pd = st_r[0].ty * cfg.cos_coef;
    st_nxt[1].q  = st_r[0].ty * cfg.neg_tan_half_coef;

    st_nxt[2]     = st_r[1];
    st_nxt[2].dx5 = pgr_pkg::trunc_frac(pgr_pkg::acc_t'(st_r[1].pa) +
                      pgr_pkg::acc_t'(st_r[1].pb) -
                      (pgr_pkg::acc_t'(cfg.offset_x) <<< pgr_pkg::FRAC_BITS));
    st_nxt[2].dy5 = pgr_pkg::trunc_frac(pgr_pkg::acc_t'(st_r[1].pd) -
                      pgr_pkg::acc_t'(st_r[1].pc) -
                      (pgr_pkg::acc_t'(cfg.offset_y) <<< pgr_pkg::FRAC_BITS));
    t_x1 = pgr_pkg::trunc_frac((pgr_pkg::acc_t'(st_r[1].tx) <<< pgr_pkg::FRAC_BITS) +
                               pgr_pkg::acc_t'(st_r[1].q));
    st_nxt[2].x1 = t_x1[pgr_pkg::X1_W-1:0];

    st_nxt[3]   = st_r[2];
    st_nxt[3].r = st_r[2].x1 * cfg.sin_coef;

    st_nxt[4] = st_r[3];
    t_y1 = pgr_pkg::trunc_frac(pgr_pkg::acc_t'(st_r[3].r) +
                               (pgr_pkg::acc_t'(st_r[3].ty) <<< pgr_pkg::FRAC_BITS));
    st_nxt[4].y1 = t_y1[pgr_pkg::Y1_W-1:0];

    st_nxt[5]   = st_r[4];
    st_nxt[5].s = st_r[4].y1 * cfg.neg_tan_half_coef;

    st_nxt[6] = st_r[5];
    t_x2 = pgr_pkg::trunc_frac((pgr_pkg::acc_t'(st_r[5].x1) <<< pgr_pkg::FRAC_BITS) +
                               pgr_pkg::acc_t'(st_r[5].s));
    case (st_r[5].mode)
      pgr_pkg::MODE_ROTATE: begin
        st_nxt[6].dx = st_r[5].dx5;
        st_nxt[6].dy = st_r[5].dy5;
      end
      pgr_pkg::MODE_SHEAR: begin
        st_nxt[6].dx = t_x2 - pgr_pkg::D_W'(cfg.offset_x);
        st_nxt[6].dy = pgr_pkg::D_W'(st_r[5].y1) - pgr_pkg::D_W'(cfg.offset_y);
      end
      default: begin
        st_nxt[6].dx = pgr_pkg::D_W'(st_r[5].fdx);
        st_nxt[6].dy = pgr_pkg::D_W'(st_r[5].fdy);
      end
    endcase

    lst  = st_r[NST-1];
    fw_s = $signed(pgr_pkg::D_W'(lst.fw));
    fh_s = $signed(pgr_pkg::D_W'(lst.fh));
    ok_o = lst.ok && !lst.dx[pgr_pkg::D_W-1] && !lst.dy[pgr_pkg::D_W-1] &&
           (lst.dx < fw_s) && (lst.dy < fh_s) &&
           (lst.dx[pgr_pkg::D_W-1:pgr_pkg::COORD_BITS] == '0) &&
           (lst.dy[pgr_pkg::D_W-1:pgr_pkg::COORD_BITS] == '0);
    res_nxt.dst_x     = ok_o ? lst.dx[pgr_pkg::COORD_BITS-1:0] : '0;
    res_nxt.dst_y     = ok_o ? lst.dy[pgr_pkg::COORD_BITS-1:0] : '0;
    res_nxt.out_red   = lst.red;
    res_nxt.out_green = lst.green;
    res_nxt.out_blue  = lst.blue;
    res_nxt.in_frame  = ok_o;

    vld_nxt = {vld_r[pgr_pkg::PIPE_DEPTH-2:0], in_vld};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NST; i++) begin
      st_r[i] <= st_nxt[i];
    end
    res_r <= res_nxt;
  end

  assign out_vld = vld_r[pgr_pkg::PIPE_DEPTH-1];
  assign out_res = res_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld |-> ##(pgr_pkg::PIPE_DEPTH) out_vld)
    else $error("Request did not emerge after the pipeline depth.");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> $past(in_vld, pgr_pkg::PIPE_DEPTH))
    else $error("Result strobe without a matching request.");

  a_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld && !out_res.in_frame) |-> (out_res.dst_x == '0 && out_res.dst_y == '0))
    else $error("Dropped pixel carries non-zero coordinates.");

endmodule

`default_nettype wire

/* src/pixel_geometric_remap.sv */
// Channel   Ports                              Handshake
// in        start, busy, in_pix                accepted when start && !busy
// out       out_strobe, out_res                one cycle per result, no back-pressure
// cfg       cfg_we, cfg_index, cfg_data        written when cfg_we is high
//
// One pixel may be accepted in every cycle; busy is always low.
// Each result reaches the ports through an offset stage, three multiply stages
// each followed by a truncation stage, and the output register behind the
// frame check.
// Reset is synchronous and active low; it clears the stage valid bits and
// loads the register defaults. There is no stall path, as results cannot be held.
`default_nettype none

module pixel_geometric_remap (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire pgr_pkg::pix_req_t              in_pix,
  output logic                                out_strobe,
  output pgr_pkg::pix_res_t                   out_res,
  input  wire logic                           cfg_we,
  input  wire logic [pgr_pkg::CIDX_W-1:0]     cfg_index,
  input  wire logic [pgr_pkg::CDAT_W-1:0]     cfg_data
);

  pgr_pkg::cfg_t cfg_r;
  pgr_pkg::cfg_t cfg_nxt;
  logic          in_vld;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (pgr_pkg::cfg_idx_t'(cfg_index))
        pgr_pkg::CFG_MODE:     cfg_nxt.mode = pgr_pkg::mode_t'(cfg_data[pgr_pkg::MODE_W-1:0]);
        pgr_pkg::CFG_WIDTH:    cfg_nxt.image_width = cfg_data[pgr_pkg::DIM_W-1:0];
        pgr_pkg::CFG_HEIGHT:   cfg_nxt.image_height = cfg_data[pgr_pkg::DIM_W-1:0];
        pgr_pkg::CFG_COS:      cfg_nxt.cos_coef = $signed(cfg_data[pgr_pkg::COEF_W-1:0]);
        pgr_pkg::CFG_SIN:      cfg_nxt.sin_coef = $signed(cfg_data[pgr_pkg::COEF_W-1:0]);
        pgr_pkg::CFG_NEG_TAN:  cfg_nxt.neg_tan_half_coef =
                                 $signed(cfg_data[pgr_pkg::COEF_W-1:0]);
        pgr_pkg::CFG_OFFSET_X: cfg_nxt.offset_x = $signed(cfg_data[pgr_pkg::OFS_W-1:0]);
        pgr_pkg::CFG_OFFSET_Y: cfg_nxt.offset_y = $signed(cfg_data[pgr_pkg::OFS_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode              <= pgr_pkg::MODE_CW90;
      cfg_r.image_width       <= pgr_pkg::DIM_W'(1);
      cfg_r.image_height      <= pgr_pkg::DIM_W'(1);
      cfg_r.cos_coef          <= pgr_pkg::COEF_W'(1 << pgr_pkg::FRAC_BITS);
      cfg_r.sin_coef          <= '0;
      cfg_r.neg_tan_half_coef <= '0;
      cfg_r.offset_x          <= '0;
      cfg_r.offset_y          <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign busy   = 1'b0;
  assign in_vld = start && !busy;

  pgr_pipe u_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_vld),
    .in_pix  (in_pix),
    .cfg     (cfg_r),
    .out_vld (out_strobe),
    .out_res (out_res)
  );

endmodule

`default_nettype wire
